### rtl/mep_pkg.sv
// shared types, widths and colour tables for the escape-time pixel block
`default_nettype none

package mep_pkg;

    // fixed-point format of z and c
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 10;
    localparam int IN_W       = 32;
    localparam int IN_FRAC    = 28;
    localparam int CH_W       = 8;

    // c and z hold sign, three integer bits and the fraction
    localparam int C_W = FRAC_BITS + 4;
    localparam int Z_W = FRAC_BITS + 4;
    // multiplier operand: each component of z is in [-2, 2] once the large-component test passes
    localparam int M_W = FRAC_BITS + 3;
    localparam int P_W = 2 * M_W;
    // headroom for sums of squares and for z*z + c before clamping
    localparam int S_W = FRAC_BITS + 6;

    // input conversion shifts
    localparam int SHL = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
    localparam int SHR = (FRAC_BITS >= IN_FRAC) ? 0 : (IN_FRAC - FRAC_BITS);

    localparam logic signed [S_W-1:0] Z_TWO  = S_W'(1) << (FRAC_BITS + 1);
    localparam logic signed [S_W-1:0] Z_FOUR = S_W'(1) << (FRAC_BITS + 2);

    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(992);
    localparam logic [COUNT_BITS-1:0] BLACK_COUNT = COUNT_BITS'(255);

    localparam int MOD_A   = 11;
    localparam int MOD_B   = 19;
    localparam int MODA_W  = $clog2(MOD_A);
    localparam int MODB_W  = $clog2(MOD_B);

    // stream payload layout
    localparam int IN_TDATA_W  = 2 * IN_W;
    localparam int OUT_BITS    = COUNT_BITS + 3 * CH_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD     = OUT_TDATA_W - OUT_BITS;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // take a new point, clear z and the count
        logic step;    // do one iteration
        logic finish;  // capture count and colour into the result register
    } mep_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic escaped;   // large component or |z|^2 > 4
        logic at_limit;  // count reached the limit
    } mep_status_t;

    // blue: min(255, floor((idx+1)*255/9))
    function automatic logic [CH_W-1:0] blue_lut(input logic [MODA_W-1:0] idx);
        logic [CH_W-1:0] v;
        case (idx)
            4'd0:    v = 8'd28;
            4'd1:    v = 8'd56;
            4'd2:    v = 8'd85;
            4'd3:    v = 8'd113;
            4'd4:    v = 8'd141;
            4'd5:    v = 8'd170;
            4'd6:    v = 8'd198;
            4'd7:    v = 8'd226;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // green: min(255, floor((idx+1)*255/5))
    function automatic logic [CH_W-1:0] green_lut(input logic [MODA_W-1:0] idx);
        logic [CH_W-1:0] v;
        case (idx)
            4'd0:    v = 8'd51;
            4'd1:    v = 8'd102;
            4'd2:    v = 8'd153;
            4'd3:    v = 8'd204;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // red: min(255, floor((idx+1)*255/7))
    function automatic logic [CH_W-1:0] red_lut(input logic [MODB_W-1:0] idx);
        logic [CH_W-1:0] v;
        case (idx)
            5'd0:    v = 8'd36;
            5'd1:    v = 8'd72;
            5'd2:    v = 8'd109;
            5'd3:    v = 8'd145;
            5'd4:    v = 8'd182;
            5'd5:    v = 8'd218;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/mep_ctrl.sv
// controller: sequences accept, iterations and result hand-off
`default_nettype none

module mep_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire mep_pkg::mep_status_t status,
    output mep_pkg::mep_cmd_t        cmd
);
    import mep_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   stop;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign stop     = status.escaped | status.at_limit;
    assign out_free = ~m_valid_reg | m_tready;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg & ~m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!stop)
                begin
                    cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mep_datapath.sv
// datapath: z iteration, count, limit register, colour and result register
`default_nettype none

module mep_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic signed [mep_pkg::IN_W-1:0]       point_real,
    input  wire logic signed [mep_pkg::IN_W-1:0]       point_imag,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [mep_pkg::COUNT_BITS-1:0]        cfg_wr_data,
    input  wire mep_pkg::mep_cmd_t                     cmd,
    output mep_pkg::mep_status_t                       status,
    output logic [mep_pkg::COUNT_BITS-1:0]             iteration_count,
    output logic [mep_pkg::CH_W-1:0]                   blue_level,
    output logic [mep_pkg::CH_W-1:0]                   green_level,
    output logic [mep_pkg::CH_W-1:0]                   red_level
);
    import mep_pkg::*;

    logic signed [C_W-1:0]   cr_reg, ci_reg;
    logic signed [C_W-1:0]   cr_next, ci_next;
    logic signed [Z_W-1:0]   zr_reg, zi_reg;
    logic signed [Z_W-1:0]   zr_next, zi_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [MODA_W-1:0]       moda_reg, moda_next;
    logic [MODB_W-1:0]       modb_reg, modb_next;
    logic [COUNT_BITS-1:0]   limit_reg;

    logic [COUNT_BITS-1:0]   count_out_reg;
    logic [CH_W-1:0]         blue_reg, green_reg, red_reg;

    logic signed [S_W-1:0]   zr_w, zi_w;
    logic signed [M_W-1:0]   zr_op, zi_op;
    logic signed [P_W-1:0]   prod_rr, prod_ii, prod_ri;
    logic signed [S_W-1:0]   rr, ii, ri2;
    logic signed [S_W-1:0]   sum_sq, new_r, new_i;
    logic                    big_comp;
    logic                    black;

    // input conversion to the internal format, floor when narrowing
    always_comb
    begin
        if (FRAC_BITS >= IN_FRAC)
        begin
            cr_next = C_W'(point_real) <<< SHL;
            ci_next = C_W'(point_imag) <<< SHL;
        end
        else
        begin
            cr_next = C_W'(point_real >>> SHR);
            ci_next = C_W'(point_imag >>> SHR);
        end
    end

    // squares and cross product, floored back to the fraction width
    assign zr_w    = S_W'(zr_reg);
    assign zi_w    = S_W'(zi_reg);
    assign zr_op   = zr_reg[M_W-1:0];
    assign zi_op   = zi_reg[M_W-1:0];
    assign prod_rr = zr_op * zr_op;
    assign prod_ii = zi_op * zi_op;
    assign prod_ri = zr_op * zi_op;
    assign rr      = S_W'(prod_rr >>> FRAC_BITS);
    assign ii      = S_W'(prod_ii >>> FRAC_BITS);
    assign ri2     = S_W'(prod_ri >>> (FRAC_BITS - 1));

    // escape tests
    assign big_comp = (zr_w > Z_TWO) || (zr_w < -Z_TWO) ||
                      (zi_w > Z_TWO) || (zi_w < -Z_TWO);
    assign sum_sq   = rr + ii;

    assign status.escaped  = big_comp || (sum_sq > Z_FOUR);
    assign status.at_limit = (count_reg >= limit_reg);

    // z*z + c, clamped to [-4, 4]
    assign new_r = rr - ii + S_W'(cr_reg);
    assign new_i = ri2 + S_W'(ci_reg);

    always_comb
    begin
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        count_next = count_reg;
        moda_next  = moda_reg;
        modb_next  = modb_reg;
        if (cmd.load)
        begin
            zr_next    = '0;
            zi_next    = '0;
            count_next = '0;
            moda_next  = '0;
            modb_next  = '0;
        end
        else if (cmd.step)
        begin
            if (new_r > Z_FOUR)
                zr_next = Z_W'(Z_FOUR);
            else if (new_r < -Z_FOUR)
                zr_next = Z_W'(-Z_FOUR);
            else
                zr_next = Z_W'(new_r);
            if (new_i > Z_FOUR)
                zi_next = Z_W'(Z_FOUR);
            else if (new_i < -Z_FOUR)
                zi_next = Z_W'(-Z_FOUR);
            else
                zi_next = Z_W'(new_i);
            count_next = count_reg + 1'b1;
            moda_next  = (moda_reg == MODA_W'(MOD_A - 1)) ? '0 : moda_reg + 1'b1;
            modb_next  = (modb_reg == MODB_W'(MOD_B - 1)) ? '0 : modb_reg + 1'b1;
        end
    end

    // iteration limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= cr_next;
            ci_reg <= ci_next;
        end
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        count_reg <= count_next;
        moda_reg  <= moda_next;
        modb_reg  <= modb_next;
    end

    // colour and result register
    assign black = (count_reg >= BLACK_COUNT);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            count_out_reg <= count_reg;
            blue_reg      <= black ? '0 : blue_lut(moda_reg);
            green_reg     <= black ? '0 : green_lut(moda_reg);
            red_reg       <= black ? '0 : red_lut(modb_reg);
        end
    end

    assign iteration_count = count_out_reg;
    assign blue_level      = blue_reg;
    assign green_level     = green_reg;
    assign red_level       = red_reg;

endmodule

`default_nettype wire

### rtl/mandelbrot_escape_pixel.sv
// top level of the escape-time pixel block
`default_nettype none

// Takes one point c (Q4.28 real and imaginary parts) per input beat, iterates
// z = z*z + c from zero one iteration per clock, and returns the iteration
// count with its colour. A point that stops after n iterations occupies the
// block for a load, n iterating steps and one final test that also writes
// the result register; n is at most iteration_limit, which resets to 992.
// The iteration step is combinational: three 31 by 31 multipliers feed the
// escape test and the clamped update of z. The result register lets the
// next point load while a result waits; if that result is still waiting
// when the next point finishes, the point holds in its final test until
// the result beat is taken. The user must write iteration_limit through
// cfg_wr_en / cfg_wr_data only while no point is in flight and no result
// is pending; the block does not enforce this.
module mandelbrot_escape_pixel (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input beat: point_real [31:0], point_imag [63:32]
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mep_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result beat: iteration_count [9:0], blue_level [17:10],
    // green_level [25:18], red_level [33:26], zero [39:34]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mep_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // iteration_limit write
    input  wire logic                                cfg_wr_en,
    input  wire logic [mep_pkg::COUNT_BITS-1:0]      cfg_wr_data
);
    import mep_pkg::*;

    mep_cmd_t              cmd;
    mep_status_t           status;
    logic [COUNT_BITS-1:0] iteration_count;
    logic [CH_W-1:0]       blue_level, green_level, red_level;

    mep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mep_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .point_real      (s_tdata[IN_W-1:0]),
        .point_imag      (s_tdata[2*IN_W-1:IN_W]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .status          (status),
        .iteration_count (iteration_count),
        .blue_level      (blue_level),
        .green_level     (green_level),
        .red_level       (red_level)
    );

    // pack the result beat
    assign m_tdata = {{OUT_PAD{1'b0}}, red_level, green_level, blue_level, iteration_count};

    // at most one command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.finish}))
        else $error("controller issued more than one command");

    // no new point accepted while iterating
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !s_tready)
        else $error("input ready during iteration");

    // a finished point always presents a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_tvalid)
        else $error("finished point produced no result beat");

    // counts of 255 and above are black
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[COUNT_BITS-1:0] >= BLACK_COUNT))
            |-> (m_tdata[OUT_BITS-1:COUNT_BITS] == '0))
        else $error("non-black colour for a high count");

endmodule

`default_nettype wire
